// ----- hw/rtl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg
// Types, constants and helpers shared by the trapezoidal profile sampler.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int TimeW  = 32;
   localparam int AccW   = 32;
   localparam int PosW   = 48;
   localparam int ProdW  = 64;
   localparam int QW     = 67;
   localparam int CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] REG_START_POSITION = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_ACCEL_VALUE    = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_RAMP_TIME      = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_CRUISE_TIME    = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_START_TIME     = 3'd4;

   localparam logic [PosW-1:0] POS_MAX = {1'b0, {(PosW-1){1'b1}}};
   localparam logic [PosW-1:0] POS_MIN = {1'b1, {(PosW-1){1'b0}}};
   localparam logic [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};
   localparam logic [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};

   typedef enum logic [2:0] {
      PHASE_BEFORE = 3'd0,
      PHASE_ACCEL  = 3'd1,
      PHASE_CRUISE = 3'd2,
      PHASE_DECEL  = 3'd3,
      PHASE_DONE   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [PosW-1:0]  start_position;
      logic [AccW-1:0]  accel_value;
      logic [TimeW-1:0] ramp_time;
      logic [TimeW-1:0] cruise_time;
      logic [TimeW-1:0] start_time;
   } cfg_type;

   // elapsed time, decel offset and velocity time base of one query
   typedef struct packed {
      phase_type        phase;
      logic [TimeW-1:0] t;
      logic [TimeW-1:0] d;
      logic [TimeW-1:0] vt;
   } timing_type;

   // time-squared quantity and finished velocity
   typedef struct packed {
      phase_type       phase;
      logic [QW-1:0]   q;
      logic [PosW-1:0] velocity;
   } quad_type;

   typedef struct packed {
      logic [PosW-1:0] position;
      logic [PosW-1:0] velocity;
      logic [AccW-1:0] accel_out;
      phase_type       phase;
      logic            saturated;
   } result_type;

   function automatic logic [AccW-1:0] accel_mag(input logic [AccW-1:0] a);
      accel_mag = a[AccW-1] ? (~a + AccW'(1)) : a;
   endfunction

endpackage

// ----- hw/rtl/tps_channels.sv -----
// ----------------------------------------------------------------------------
// tps_channels
// Query and result channels of the trapezoidal profile sampler.
// ----------------------------------------------------------------------------
interface tps_req_if;
   logic                        valid;
   logic                        ready;
   logic [tps_pkg::TimeW-1:0]   query_time;

   modport source (output valid, output query_time, input ready);
   modport sink   (input valid, input query_time, output ready);
endinterface

interface tps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tps_pkg::PosW-1:0]    position;
   logic [tps_pkg::PosW-1:0]    velocity;
   logic [tps_pkg::AccW-1:0]    accel_out;
   logic [2:0]                  phase;
   logic                        saturated;

   modport source (output valid, output position, output velocity, output accel_out,
                   output phase, output saturated, input ready);
   modport sink   (input valid, input position, input velocity, input accel_out,
                   input phase, input saturated, output ready);
endinterface

// ----- hw/rtl/tps_phase.sv -----
// ----------------------------------------------------------------------------
// tps_phase
// Stage 1: elapsed time, phase decision, decel offset and velocity time base.
// ----------------------------------------------------------------------------
module tps_phase (
   input  logic                 clock,
   input  logic                 reset,
   input  tps_pkg::cfg_type     cfg,
   tps_req_if.sink              req_chan,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tps_pkg::timing_type  out_item
);

   logic                valid_ff;
   tps_pkg::timing_type item_ff;
   tps_pkg::timing_type item_in;
   logic                take;

   logic [tps_pkg::TimeW-1:0] t;
   logic [tps_pkg::TimeW:0]   lim2;
   logic [tps_pkg::TimeW+1:0] lim3;
   logic [tps_pkg::TimeW+1:0] vt_dec;

   assign req_chan.ready = !valid_ff || out_ready;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      t      = req_chan.query_time - cfg.start_time;
      lim2   = {1'b0, cfg.ramp_time} + {1'b0, cfg.cruise_time};
      lim3   = {1'b0, lim2} + {2'b00, cfg.ramp_time};
      vt_dec = lim3 - {2'b00, t};
      item_in.t  = t;
      item_in.d  = t - cfg.ramp_time - cfg.cruise_time;
      item_in.vt = '0;
      if (req_chan.query_time < cfg.start_time) begin
         item_in.phase = tps_pkg::PHASE_BEFORE;
      end else if (t <= cfg.ramp_time) begin
         item_in.phase = tps_pkg::PHASE_ACCEL;
         item_in.vt    = t;
      end else if ({1'b0, t} <= lim2) begin
         item_in.phase = tps_pkg::PHASE_CRUISE;
         item_in.vt    = cfg.ramp_time;
      end else if ({2'b00, t} <= lim3) begin
         item_in.phase = tps_pkg::PHASE_DECEL;
         item_in.vt    = vt_dec[tps_pkg::TimeW-1:0];
      end else begin
         item_in.phase = tps_pkg::PHASE_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- hw/rtl/tps_quad.sv -----
// ----------------------------------------------------------------------------
// tps_quad
// Stages 2 and 3: time products, time-squared sum per phase, rounded velocity.
// ----------------------------------------------------------------------------
module tps_quad (
   input  logic                 clock,
   input  logic                 reset,
   input  tps_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tps_pkg::timing_type  in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tps_pkg::quad_type    out_item
);

   localparam int PW = tps_pkg::ProdW;
   localparam int QW = tps_pkg::QW;

   // stage 2 registers
   logic                s2_valid_ff;
   logic                s2_ready;
   tps_pkg::phase_type  s2_phase_ff;
   logic [PW-1:0]       s2_tx_ff, s2_tx_in;
   logic [PW-1:0]       s2_cc_ff, s2_cc_in;
   logic [PW-1:0]       s2_yy_ff, s2_yy_in;
   logic [PW-1:0]       s2_vp_ff, s2_vp_in;

   // stage 3 registers
   logic                s3_valid_ff;
   logic                s3_ready;
   tps_pkg::quad_type   s3_item_ff, s3_item_in;

   logic [tps_pkg::TimeW-1:0] x_sel, y_sel;
   logic [tps_pkg::AccW-1:0]  amag;
   logic [QW-1:0]             tx2, cc, yy;
   logic [PW-1:0]             vround;
   logic [tps_pkg::PosW-1:0]  vmag;

   assign amag = tps_pkg::accel_mag(cfg.accel_value);

   always_comb begin
      x_sel = (in_item.phase == tps_pkg::PHASE_DONE) ? cfg.cruise_time : in_item.t;
      y_sel = (in_item.phase == tps_pkg::PHASE_DECEL) ? in_item.d : in_item.t;
      s2_tx_in = PW'(cfg.ramp_time) * PW'(x_sel);
      s2_cc_in = PW'(cfg.ramp_time) * PW'(cfg.ramp_time);
      s2_yy_in = PW'(y_sel) * PW'(y_sel);
      s2_vp_in = PW'(amag) * PW'(in_item.vt);
   end

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign in_ready = s2_ready;

   always_comb begin
      tx2    = {QW'(s2_tx_ff)} << 1;
      cc     = QW'(s2_cc_ff);
      yy     = QW'(s2_yy_ff);
      vround = s2_vp_ff + PW'(1 << 15);
      vmag   = vround[PW-1:16];
      s3_item_in.phase    = s2_phase_ff;
      s3_item_in.velocity = cfg.accel_value[tps_pkg::AccW-1] ? (~vmag + 48'd1) : vmag;
      case (s2_phase_ff)
         tps_pkg::PHASE_ACCEL:  s3_item_in.q = yy;
         tps_pkg::PHASE_CRUISE: s3_item_in.q = tx2 - cc;
         tps_pkg::PHASE_DECEL:  s3_item_in.q = tx2 - cc - yy;
         tps_pkg::PHASE_DONE:   s3_item_in.q = tx2 + (cc << 1);
         default:               s3_item_in.q = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s2_ready) begin
         s2_phase_ff <= in_item.phase;
         s2_tx_ff    <= s2_tx_in;
         s2_cc_ff    <= s2_cc_in;
         s2_yy_ff    <= s2_yy_in;
         s2_vp_ff    <= s2_vp_in;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

// ----- hw/rtl/tps_scale.sv -----
// ----------------------------------------------------------------------------
// tps_scale
// Stages 4 to 6: scale by acceleration, round, offset by start position, clip.
// ----------------------------------------------------------------------------
module tps_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  tps_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tps_pkg::quad_type    in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tps_pkg::result_type  out_item
);

   localparam int PW   = tps_pkg::ProdW;
   localparam int QW   = tps_pkg::QW;
   localparam int AW   = tps_pkg::AccW;
   localparam int PosW = tps_pkg::PosW;
   localparam int HiW  = PW + 4;
   localparam int TopW = QW - PW;

   // stage 4: partial products of q times |a|
   logic                s4_valid_ff, s4_ready;
   tps_pkg::phase_type  s4_phase_ff;
   logic [PosW-1:0]     s4_vel_ff;
   logic [PW-1:0]       s4_pp0_ff, s4_pp0_in;
   logic [PW-1:0]       s4_pp1_ff, s4_pp1_in;
   logic [TopW+AW-1:0]  s4_pp2_ff, s4_pp2_in;

   // stage 5: rounded magnitude of the position term
   logic                s5_valid_ff, s5_ready;
   tps_pkg::phase_type  s5_phase_ff;
   logic [PosW-1:0]     s5_vel_ff;
   logic [PosW:0]       s5_mag_ff, s5_mag_in;

   // stage 6: result register
   logic                s6_valid_ff, s6_ready;
   tps_pkg::result_type s6_item_ff, s6_item_in;

   logic [AW-1:0]        amag;
   logic [HiW-1:0]       hi;
   logic signed [PosW+1:0] pos_wide;
   logic signed [PosW+1:0] start_wide;
   logic signed [PosW+1:0] mag_wide;
   logic                 over, under;

   assign amag = tps_pkg::accel_mag(cfg.accel_value);

   always_comb begin
      s4_pp0_in = PW'(in_item.q[31:0]) * PW'(amag);
      s4_pp1_in = PW'(in_item.q[63:32]) * PW'(amag);
      s4_pp2_in = (TopW+AW)'(in_item.q[QW-1:64]) * (TopW+AW)'(amag);
   end

   // product plus half of the dropped weight; bit 32 and below fall off
   always_comb begin
      hi = HiW'(s4_pp0_ff[PW-1:32]) + HiW'(s4_pp1_ff) + HiW'({s4_pp2_ff, 32'd0})
         + HiW'(1);
      if (|hi[HiW-1:PosW+1]) begin
         s5_mag_in = {1'b1, {PosW{1'b0}}};
      end else begin
         s5_mag_in = {1'b0, hi[PosW:1]};
      end
   end

   always_comb begin
      start_wide = {{2{cfg.start_position[PosW-1]}}, cfg.start_position};
      mag_wide   = {1'b0, s5_mag_ff};
      pos_wide   = cfg.accel_value[AW-1] ? (start_wide - mag_wide)
                                         : (start_wide + mag_wide);
      over  = !pos_wide[PosW+1] && (pos_wide[PosW:PosW-1] != 2'b00);
      under = pos_wide[PosW+1] && (pos_wide[PosW:PosW-1] != 2'b11);
      s6_item_in.phase     = s5_phase_ff;
      s6_item_in.saturated = over || under;
      if (over) begin
         s6_item_in.position = tps_pkg::POS_MAX;
      end else if (under) begin
         s6_item_in.position = tps_pkg::POS_MIN;
      end else begin
         s6_item_in.position = pos_wide[PosW-1:0];
      end
      case (s5_phase_ff)
         tps_pkg::PHASE_ACCEL: begin
            s6_item_in.accel_out = cfg.accel_value;
            s6_item_in.velocity  = s5_vel_ff;
         end
         tps_pkg::PHASE_CRUISE: begin
            s6_item_in.accel_out = '0;
            s6_item_in.velocity  = s5_vel_ff;
         end
         tps_pkg::PHASE_DECEL: begin
            s6_item_in.accel_out = (cfg.accel_value == tps_pkg::ACC_MIN) ? tps_pkg::ACC_MAX
                                                                        : (~cfg.accel_value + AW'(1));
            s6_item_in.velocity  = s5_vel_ff;
         end
         default: begin
            s6_item_in.accel_out = '0;
            s6_item_in.velocity  = '0;
         end
      endcase
   end

   assign s6_ready = !s6_valid_ff || out_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_ready = s4_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (s4_ready) begin
            s4_valid_ff <= in_valid;
         end
         if (s5_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
         if (s6_ready) begin
            s6_valid_ff <= s5_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s4_ready) begin
         s4_phase_ff <= in_item.phase;
         s4_vel_ff   <= in_item.velocity;
         s4_pp0_ff   <= s4_pp0_in;
         s4_pp1_ff   <= s4_pp1_in;
         s4_pp2_ff   <= s4_pp2_in;
      end
      if (s4_valid_ff && s5_ready) begin
         s5_phase_ff <= s4_phase_ff;
         s5_vel_ff   <= s4_vel_ff;
         s5_mag_ff   <= s5_mag_in;
      end
      if (s5_valid_ff && s6_ready) begin
         s6_item_ff <= s6_item_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_item  = s6_item_ff;

endmodule

// ----- hw/rtl/trapezoidal_profile_sampler.sv -----
// ----------------------------------------------------------------------------
// trapezoidal_profile_sampler
// Samples a trapezoidal velocity profile at each queried time.
// ----------------------------------------------------------------------------
// Takes one query transaction per cycle while the result side is not stalled,
// and returns one result per query, in order. The six register stages are
// phase decision, 32x32 time products, the per-phase time-squared sum, the
// split product with the acceleration magnitude, the rounding sum, and the
// start-position offset with clipping; each stage holds its transaction while
// the next one is full, so a stalled result only stops intake once every stage
// is occupied. Write configuration only while no query is in flight.
module trapezoidal_profile_sampler (
   input  logic                              clock,
   input  logic                              reset,
   tps_req_if.sink                           req_chan,
   tps_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [tps_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [tps_pkg::PosW-1:0]          csr_write_data
);

   tps_pkg::cfg_type     cfg_ff;
   logic                 ph_valid, ph_ready;
   tps_pkg::timing_type  ph_item;
   logic                 qd_valid, qd_ready;
   tps_pkg::quad_type    qd_item;
   tps_pkg::result_type  res_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tps_pkg::REG_START_POSITION: cfg_ff.start_position <= csr_write_data;
            tps_pkg::REG_ACCEL_VALUE:    cfg_ff.accel_value    <= csr_write_data[31:0];
            tps_pkg::REG_RAMP_TIME:      cfg_ff.ramp_time      <= csr_write_data[31:0];
            tps_pkg::REG_CRUISE_TIME:    cfg_ff.cruise_time    <= csr_write_data[31:0];
            tps_pkg::REG_START_TIME:     cfg_ff.start_time     <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   tps_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .out_valid (ph_valid),
      .out_ready (ph_ready),
      .out_item  (ph_item)
   );

   tps_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (ph_valid),
      .in_ready  (ph_ready),
      .in_item   (ph_item),
      .out_valid (qd_valid),
      .out_ready (qd_ready),
      .out_item  (qd_item)
   );

   tps_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (qd_valid),
      .in_ready  (qd_ready),
      .in_item   (qd_item),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (res_item)
   );

   assign rsp_chan.position  = res_item.position;
   assign rsp_chan.velocity  = res_item.velocity;
   assign rsp_chan.accel_out = res_item.accel_out;
   assign rsp_chan.phase     = res_item.phase;
   assign rsp_chan.saturated = res_item.saturated;

   a_idle_phases_still : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.phase == tps_pkg::PHASE_BEFORE ||
                         rsp_chan.phase == tps_pkg::PHASE_DONE)
      |-> rsp_chan.velocity == '0 && rsp_chan.accel_out == '0)
      else $error("motion reported outside the moving phases");

   a_cruise_no_accel : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.phase == tps_pkg::PHASE_CRUISE
      |-> rsp_chan.accel_out == '0)
      else $error("acceleration reported while cruising");

   a_sat_at_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.saturated
      |-> rsp_chan.position == tps_pkg::POS_MAX || rsp_chan.position == tps_pkg::POS_MIN)
      else $error("clip flag set with position inside range");

   a_before_no_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.phase == tps_pkg::PHASE_BEFORE
      |-> !rsp_chan.saturated)
      else $error("clip flag set before motion start");

endmodule

// ----- tb/sv/tps_profile_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tps_profile_checker
// Watches the query, result and register ports of the profile sampler. It
// keeps its own copy of the registers, computes the expected sample for every
// accepted query and compares each accepted result, field by field and in
// order, against it. Counts of failures and pending samples go to the bench.
// ----------------------------------------------------------------------------
module tps_profile_checker
   import tps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   tps_req_if                 req_chan,
   tps_rsp_if                 rsp_chan,
   input  logic               csr_write_enable,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [PosW-1:0]    csr_write_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 checked_count,
   output int                 sat_count,
   output logic [4:0]         phases_seen
);

   localparam longint PosTop    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint PosBottom = -PosTop - 1;
   localparam int     ReportMax = 10;

   cfg_type    profile_cfg;
   result_type expected_samples[$];
   int         n_fail;
   int         n_checked;
   int         n_sat;
   logic [4:0] seen;

   initial begin
      n_fail = 0;
      n_checked = 0;
      n_sat = 0;
      seen = '0;
      fail_count = 0;
      pending_count = 0;
      checked_count = 0;
      sat_count = 0;
      phases_seen = '0;
   end

   function automatic result_type profile_sample(input cfg_type c,
                                                 input logic [TimeW-1:0] qt);
      result_type         res;
      logic [33:0]        t;
      logic [33:0]        tc;
      logic [33:0]        tv;
      logic [33:0]        d;
      logic [33:0]        vt;
      logic [127:0]       quad;
      logic [127:0]       prod;
      logic [127:0]       mag;
      logic [AccW-1:0]    amag;
      logic [63:0]        vmag;
      logic signed [63:0] pos;
      logic signed [63:0] vel;
      logic signed [63:0] base;
      logic               neg;
      tc = 34'(c.ramp_time);
      tv = 34'(c.cruise_time);
      neg = c.accel_value[AccW-1];
      amag = neg ? -c.accel_value : c.accel_value;
      base = $signed(c.start_position);
      vel = '0;
      quad = '0;
      vt = '0;
      res.accel_out = '0;
      res.saturated = 1'b0;
      if (qt < c.start_time) begin
         res.phase = PHASE_BEFORE;
         pos = base;
      end else begin
         t = 34'(qt - c.start_time);
         if (t <= tc) begin
            res.phase = PHASE_ACCEL;
            quad = t * t;
            vt = t;
            res.accel_out = c.accel_value;
         end else if (t <= tc + tv) begin
            res.phase = PHASE_CRUISE;
            quad = 2 * tc * t - tc * tc;
            vt = tc;
         end else if (t <= 2 * tc + tv) begin
            res.phase = PHASE_DECEL;
            d = t - tc - tv;
            quad = 2 * tc * t - tc * tc - d * d;
            vt = 2 * tc + tv - t;
            res.accel_out = (c.accel_value == ACC_MIN) ? ACC_MAX : -c.accel_value;
         end else begin
            res.phase = PHASE_DONE;
            quad = 2 * tc * tc + 2 * tc * tv;
         end
         // round |a|*Q/2 to the nearest position step, ties away from zero
         prod = quad * amag + (128'd1 << 32);
         mag = (prod >= (128'd1 << 81)) ? (128'd1 << 48) : (prod >> 33);
         pos = neg ? base - $signed(mag[63:0]) : base + $signed(mag[63:0]);
         if (res.phase != PHASE_DONE) begin
            vmag = (64'(amag) * 64'(vt) + 64'd32768) >> 16;
            vel = neg ? -$signed(vmag) : $signed(vmag);
         end
      end
      if (pos > PosTop) begin
         pos = PosTop;
         res.saturated = 1'b1;
      end else if (pos < PosBottom) begin
         pos = PosBottom;
         res.saturated = 1'b1;
      end
      if (vel > PosTop) begin
         vel = PosTop;
         res.saturated = 1'b1;
      end else if (vel < PosBottom) begin
         vel = PosBottom;
         res.saturated = 1'b1;
      end
      res.position = pos[PosW-1:0];
      res.velocity = vel[PosW-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         profile_cfg <= '0;
         expected_samples.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_samples.size() == 0) begin
               n_fail++;
               if (n_fail <= ReportMax)
                  $display("%0t: result transaction with no query pending", $realtime);
            end else begin
               want = expected_samples.pop_front();
               n_checked++;
               if (want.saturated) n_sat++;
               seen[want.phase] = 1'b1;
               if (rsp_chan.position !== want.position ||
                   rsp_chan.velocity !== want.velocity ||
                   rsp_chan.accel_out !== want.accel_out ||
                   rsp_chan.phase !== want.phase ||
                   rsp_chan.saturated !== want.saturated) begin
                  n_fail++;
                  if (n_fail <= ReportMax)
                     $display({"%0t: sample mismatch: expected pos %h vel %h acc %h ",
                               "phase %0d sat %b, got pos %h vel %h acc %h phase %0d sat %b"},
                              $realtime, want.position, want.velocity, want.accel_out,
                              want.phase, want.saturated, rsp_chan.position,
                              rsp_chan.velocity, rsp_chan.accel_out, rsp_chan.phase,
                              rsp_chan.saturated);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_samples.push_back(profile_sample(profile_cfg, req_chan.query_time));
         if (csr_write_enable) begin
            case (csr_index)
               REG_START_POSITION: profile_cfg.start_position <= csr_write_data;
               REG_ACCEL_VALUE:    profile_cfg.accel_value <= csr_write_data[AccW-1:0];
               REG_RAMP_TIME:      profile_cfg.ramp_time <= csr_write_data[TimeW-1:0];
               REG_CRUISE_TIME:    profile_cfg.cruise_time <= csr_write_data[TimeW-1:0];
               REG_START_TIME:     profile_cfg.start_time <= csr_write_data[TimeW-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_samples.size();
      fail_count <= n_fail;
      checked_count <= n_checked;
      sat_count <= n_sat;
      phases_seen <= seen;
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the trapezoidal profile sampler. Directed queries
// hit every phase boundary, zero ramps, rounding ties, clipping and the
// negated minimum acceleration; random profiles follow, with queries placed
// mostly inside the profile and bursts of idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import tps_pkg::*;

   localparam int ItemTarget = 1550;
   localparam int StallLimit = 2000;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [CsrIdxW-1:0] csr_index;
   logic [PosW-1:0]    csr_write_data;

   int                 fail_count;
   int                 pending_count;
   int                 checked_count;
   int                 sat_count;
   logic [4:0]         phases_seen;

   int                 gap_pct = 20;
   int                 stall_pct = 20;
   bit                 calm = 1'b0;
   int                 queries_sent = 0;
   int                 profiles_run = 0;
   int                 idle_cycles;
   logic [TimeW-1:0]   cur_t0 = '0;
   logic [TimeW-1:0]   cur_ramp = '0;
   logic [TimeW-1:0]   cur_cruise = '0;

   tps_req_if req_chan ();
   tps_rsp_if rsp_chan ();

   trapezoidal_profile_sampler u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tps_profile_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .sat_count        (sat_count),
      .phases_seen      (phases_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(99) < stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge clock);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < StallLimit) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("FAIL trapezoidal_profile_sampler");
      $finish;
   end

   task automatic send_query(input logic [TimeW-1:0] qt);
      if (!calm && $urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.query_time <= qt;
      do @(posedge clock); while (!req_chan.ready);
      queries_sent++;
   endtask

   // hold off until every sample in flight has been returned
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [PosW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic load_profile(input logic [PosW-1:0] p0, input logic [AccW-1:0] acc,
                               input logic [TimeW-1:0] ramp, input logic [TimeW-1:0] cruise,
                               input logic [TimeW-1:0] t0);
      write_reg(REG_START_POSITION, p0);
      write_reg(REG_ACCEL_VALUE, {{(PosW-AccW){acc[AccW-1]}}, acc});
      write_reg(REG_RAMP_TIME, PosW'(ramp));
      write_reg(REG_CRUISE_TIME, PosW'(cruise));
      write_reg(REG_START_TIME, PosW'(t0));
      csr_write_enable <= 1'b0;
      cur_t0 = t0;
      cur_ramp = ramp;
      cur_cruise = cruise;
      profiles_run++;
   endtask

   function automatic logic [TimeW-1:0] extreme_word();
      case ($urandom_range(2))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(2))
         0: return 0;
         1: return 5;
         default: return 25;
      endcase
   endfunction

   task automatic random_profile();
      logic [PosW-1:0]  p0;
      logic [AccW-1:0]  acc;
      logic [TimeW-1:0] ramp;
      logic [TimeW-1:0] cruise;
      logic [TimeW-1:0] t0;
      int               pick;
      pick = $urandom_range(9);
      if (pick <= 3) begin
         ramp = $urandom_range(32'h0003_0000);
         cruise = $urandom_range(32'h0003_0000);
         t0 = $urandom_range(32'h0010_0000);
      end else if (pick <= 6) begin
         ramp = $urandom_range(32'h0100_0000);
         cruise = $urandom_range(32'h0100_0000);
         t0 = $urandom_range(32'h1000_0000);
      end else if (pick == 7) begin
         ramp = $urandom();
         cruise = $urandom();
         t0 = $urandom();
      end else if (pick == 8) begin
         ramp = '0;
         cruise = $urandom_range(1) ? '0 : $urandom_range(32'h0004_0000);
         t0 = $urandom_range(32'h0001_0000);
      end else begin
         ramp = extreme_word();
         cruise = extreme_word();
         t0 = extreme_word();
      end
      case ($urandom_range(5))
         0: acc = ACC_MIN;
         1: acc = ACC_MAX;
         2: acc = '0;
         3: acc = $urandom_range(32'h0010_0000) - 32'h0008_0000;
         default: acc = $urandom();
      endcase
      case ($urandom_range(4))
         0: p0 = POS_MAX;
         1: p0 = POS_MIN;
         2: p0 = '0;
         default: p0 = PosW'({$urandom(), $urandom()});
      endcase
      gap_pct = calm ? 0 : pick_pct();
      stall_pct = calm ? 0 : pick_pct();
      load_profile(p0, acc, ramp, cruise, t0);
   endtask

   // place most queries inside the profile, some on its boundaries
   function automatic logic [TimeW-1:0] pick_query();
      longint t0;
      longint e1;
      longint e2;
      longint e3;
      longint q;
      t0 = cur_t0;
      e1 = t0 + cur_ramp;
      e2 = e1 + cur_cruise;
      e3 = e2 + cur_ramp;
      case ($urandom_range(9))
         0: q = (cur_t0 == 0) ? 0 : $urandom_range(cur_t0 - 1);
         1: q = t0 + $urandom_range(cur_ramp);
         2: q = e1 + $urandom_range(cur_cruise);
         3: q = e2 + $urandom_range(cur_ramp);
         4: q = e3 + $urandom_range(32'h0002_0000);
         5, 6: begin
            case ($urandom_range(3))
               0: q = t0;
               1: q = e1;
               2: q = e2;
               default: q = e3;
            endcase
            q = q + longint'($urandom_range(4)) - 2;
         end
         7: q = $urandom();
         default: q = t0 + longint'({$urandom(), $urandom()} % (e3 - t0 + 1));
      endcase
      if (q < 0) q = 0;
      if (q > 64'h0000_0000_FFFF_FFFF) q = 64'h0000_0000_FFFF_FFFF;
      return q[TimeW-1:0];
   endfunction

   initial begin
      int n;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.query_time = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: zero ramp at t = 0, done afterwards
      send_query('0);
      send_query('1);

      drain();
      load_profile(48'h0000_0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
                   32'h0000_8000);
      send_query('0);
      send_query(cur_t0);
      send_query(cur_t0 + cur_ramp);
      send_query(cur_t0 + cur_ramp + 1);
      send_query(cur_t0 + cur_ramp + cur_cruise);
      send_query(cur_t0 + cur_ramp + cur_cruise + 1);
      send_query(cur_t0 + 2 * cur_ramp + cur_cruise);
      send_query(cur_t0 + 2 * cur_ramp + cur_cruise + 1);
      send_query('1);

      // minimum acceleration from the top of the range: negation clip, position clip
      drain();
      load_profile(POS_MAX, ACC_MIN, 32'h4000_0000, 32'h1000_0000, 32'h0000_0000);
      send_query(32'h3000_0000);
      send_query(32'h6000_0000);
      send_query(32'h9000_0000);
      send_query('1);

      drain();
      load_profile(POS_MIN, ACC_MAX, '1, '1, 32'hFFFF_0000);
      send_query('0);
      send_query('1);

      // rounding ties on velocity and position with the smallest negative step
      drain();
      load_profile('0, '1, 32'h0001_0000, '0, '0);
      send_query(32'h0000_8000);
      send_query(32'h0001_0000);

      while (queries_sent < ItemTarget) begin
         drain();
         calm = (queries_sent >= ItemTarget - 200);
         random_profile();
         n = $urandom_range(140, 80);
         repeat (n) begin
            if (!calm && $urandom_range(149) == 0) drain();
            send_query(pick_query());
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Checked %0d samples over %0d register settings, %0d of them clipped.",
               checked_count, profiles_run, sat_count);
      $display("Phases reached (done down to before): %b", phases_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS trapezoidal_profile_sampler");
      else
         $display("FAIL trapezoidal_profile_sampler");
      $finish;
   end

endmodule
